FILE: rtl/ptts_pkg.sv
// Package for the periodic task and timer scheduler.
// Holds command codes and the queue word type; no dependencies.
`default_nettype none
package ptts_pkg;

  typedef enum logic [3:0] {
    CMD_TICK       = 4'd0,
    CMD_REG_TASK   = 4'd1,
    CMD_STOP_TASK  = 4'd2,
    CMD_START_TASK = 4'd3,
    CMD_SET_PERIOD = 4'd4,
    CMD_REG_TIMER  = 4'd5,
    CMD_READ_TIMER = 4'd6,
    CMD_RELOAD     = 4'd7,
    CMD_START_TMR  = 4'd8,
    CMD_STOP_TMR   = 4'd9
  } cmd_e;

  localparam logic [0:0] CFG_TICK_LENGTH = 1'b0;
  localparam logic [0:0] CFG_TIMER_CAP   = 1'b1;

  typedef struct packed {
    logic [3:0]  cmd;
    logic [3:0]  slot;
    logic [31:0] tv;
  } cmd_word_t;

endpackage
`default_nettype wire

FILE: rtl/ptts_front.sv
// Front end: accepts command words into a short queue.
// Depends on ptts_pkg.
`default_nettype none
module ptts_front
  import ptts_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  cmd_word_t      word_i,
  input  wire logic      pop_i,
  output logic           full_o,
  output logic           empty_o,
  output cmd_word_t      word_o
);
  cmd_word_t  mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign word_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) mem_q[wp_q] <= word_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push_i && !full_o) wp_q <= ~wp_q;
      if (pop_i && !empty_o) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i && !full_o} - {1'b0, pop_i && !empty_o};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty_o && !push_i) |=> empty_o) else $error("queue filled without push");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !pop_i) |=> full_o) else $error("queue drained without pop");
endmodule
`default_nettype wire

FILE: rtl/ptts_mod.sv
// Iterative remainder unit: value mod divisor, two bits per cycle.
// No dependencies.
`default_nettype none
module ptts_mod (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        go_i,
  input  wire logic [31:0] val_i,
  input  wire logic [15:0] div_i,
  output logic             done_o,
  output logic             zero_o
);
  logic [31:0] val_q;
  logic [16:0] rem_q;
  logic [15:0] div_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [16:0] sh;
  logic [16:0] r1;
  logic [16:0] sh2;
  logic [16:0] r2;

  assign sh     = {rem_q[15:0], val_q[31]};
  assign r1     = (sh >= {1'b0, div_q}) ? sh - {1'b0, div_q} : sh;
  assign sh2    = {r1[15:0], val_q[30]};
  assign r2     = (sh2 >= {1'b0, div_q}) ? sh2 - {1'b0, div_q} : sh2;
  assign done_o = busy_q && (cnt_q == 6'd16);
  assign zero_o = (rem_q == 17'd0);

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      val_q <= val_i; div_q <= div_i; rem_q <= '0;
    end else if (busy_q && cnt_q != 6'd16) begin
      val_q <= {val_q[29:0], 2'b00};
      rem_q <= r2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else if (go_i) begin
      busy_q <= 1'b1; cnt_q <= '0;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 6'd1;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/ptts_back.sv
// Back end: executes commands; walks channels one per cycle on a tick.
// Depends on ptts_pkg and ptts_mod.
`default_nettype none
module ptts_back
  import ptts_pkg::*;
#(
  parameter int NUM_TASKS  = 8,
  parameter int NUM_TIMERS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        avail_i,
  input  cmd_word_t        word_i,
  output logic             pop_o,
  input  wire logic [15:0] tick_len_i,
  input  wire logic [3:0]  tmr_cap_i,
  output logic             valid_o,
  output logic             ok_o,
  output logic [3:0]       new_id_o,
  output logic [31:0]      read_value_o,
  output logic [7:0]       task_fire_mask_o,
  output logic [7:0]       timer_fire_mask_o,
  output logic             idle_o
);
  localparam int TKW = $clog2(NUM_TASKS + 1);
  localparam int TMW = $clog2(NUM_TIMERS + 1);
  localparam int TKI = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int TMI = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int MX  = (NUM_TASKS > NUM_TIMERS) ? NUM_TASKS : NUM_TIMERS;
  localparam int IW  = $clog2(MX + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MOD  = 4'b0010,
    S_TMR  = 4'b0100,
    S_TSK  = 4'b1000
  } state_e;

  state_e              state_q;
  cmd_word_t           w_q;
  logic [31:0]         period_q  [NUM_TASKS];
  logic [31:0]         elapsed_q [NUM_TASKS];
  logic [NUM_TASKS-1:0] trun_q;
  logic [TKW-1:0]      ntask_q;
  logic [31:0]         reload_q  [NUM_TIMERS];
  logic [31:0]         remain_q  [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] mrun_q;
  logic [TMW-1:0]      ntmr_q;
  logic [IW-1:0]       idx_q;
  logic [7:0]          tm_q, xm_q;

  logic [15:0] tick;
  logic [3:0]  cap;
  logic        md_done, md_zero, md_go;
  logic        tvalid, mvalid;
  logic [TKI-1:0] tk;
  logic [TKI-1:0] ti;
  logic [TMI-1:0] mi;
  logic [32:0] esum;
  logic [31:0] enew;
  logic        need_mod;

  assign tick = (tick_len_i == 16'd0) ? 16'd1 : tick_len_i;
  assign cap  = (32'(tmr_cap_i) > NUM_TIMERS) ? 4'(NUM_TIMERS) : tmr_cap_i;
  assign tk   = TKI'(w_q.slot - 4'd1);
  assign ti   = TKI'(idx_q);
  assign mi   = TMI'(idx_q);
  assign tvalid = w_q.slot != 4'd0 && 32'(w_q.slot) <= 32'(ntask_q)
                  && 32'(w_q.slot) <= NUM_TASKS;
  assign mvalid = w_q.slot != 4'd0 && 32'(w_q.slot) <= 32'(ntmr_q)
                  && 32'(w_q.slot) <= NUM_TIMERS;
  assign pop_o  = (state_q == S_IDLE) && avail_i;
  assign idle_o = (state_q == S_IDLE);
  assign need_mod = word_i.cmd == CMD_REG_TASK || word_i.cmd == CMD_SET_PERIOD
                    || word_i.cmd == CMD_REG_TIMER;
  assign md_go  = pop_o && need_mod;
  assign esum   = {1'b0, elapsed_q[ti]} + 33'(tick);
  assign enew   = esum[32] ? 32'hFFFF_FFFF : esum[31:0];

  ptts_mod u_mod (
    .clk_i, .rst_ni, .go_i(md_go), .val_i(word_i.tv), .div_i(tick),
    .done_o(md_done), .zero_o(md_zero)
  );

  always_ff @(posedge clk_i) begin
    if (pop_o) w_q <= word_i;
    if (state_q == S_MOD && md_done) begin
      unique case (w_q.cmd)
        CMD_REG_TASK: if (md_zero && w_q.tv >= 32'(tick)
                          && 32'(ntask_q) < NUM_TASKS)
          period_q[TKI'(ntask_q)] <= w_q.tv;
        CMD_SET_PERIOD: if (tvalid && md_zero && w_q.tv >= 32'(tick))
          period_q[tk] <= w_q.tv;
        CMD_REG_TIMER: if (md_zero && 32'(ntmr_q) < 32'(cap))
          reload_q[TMI'(ntmr_q)] <= w_q.tv;
        default: ;
      endcase
    end
    if (state_q == S_IDLE && avail_i && word_i.cmd == CMD_RELOAD) begin
      if (word_i.slot != 4'd0 && 32'(word_i.slot) <= 32'(ntmr_q)
          && 32'(word_i.slot) <= NUM_TIMERS)
        reload_q[TMI'(word_i.slot - 4'd1)] <= word_i.tv;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; valid_o <= 1'b0; ok_o <= 1'b0; new_id_o <= '0;
      read_value_o <= '0; task_fire_mask_o <= '0; timer_fire_mask_o <= '0;
      trun_q <= '0; mrun_q <= '0; ntask_q <= '0; ntmr_q <= '0;
      idx_q <= '0; tm_q <= '0; xm_q <= '0;
      for (int i = 0; i < NUM_TASKS; i++) elapsed_q[i] <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) remain_q[i] <= '0;
    end else begin
      valid_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (avail_i) begin
            ok_o <= 1'b0; new_id_o <= '0; read_value_o <= '0;
            task_fire_mask_o <= '0; timer_fire_mask_o <= '0;
            if (need_mod) state_q <= S_MOD;
            else if (word_i.cmd == CMD_TICK) begin
              idx_q <= '0; tm_q <= '0; xm_q <= '0; state_q <= S_TMR;
            end else begin
              valid_o <= 1'b1;
              case (word_i.cmd)
                CMD_STOP_TASK, CMD_START_TASK: begin
                  if (word_i.slot != 4'd0 && 32'(word_i.slot) <= 32'(ntask_q)
                      && 32'(word_i.slot) <= NUM_TASKS
                      && trun_q[TKI'(word_i.slot - 4'd1)]
                         == (word_i.cmd == CMD_STOP_TASK)) begin
                    trun_q[TKI'(word_i.slot - 4'd1)] <=
                      (word_i.cmd == CMD_START_TASK);
                    ok_o <= 1'b1;
                  end
                end
                CMD_READ_TIMER, CMD_RELOAD, CMD_START_TMR, CMD_STOP_TMR: begin
                  if (word_i.slot != 4'd0 && 32'(word_i.slot) <= 32'(ntmr_q)
                      && 32'(word_i.slot) <= NUM_TIMERS) begin
                    ok_o <= 1'b1;
                    case (word_i.cmd)
                      CMD_READ_TIMER:
                        read_value_o <= remain_q[TMI'(word_i.slot - 4'd1)];
                      CMD_RELOAD: begin
                        remain_q[TMI'(word_i.slot - 4'd1)] <= word_i.tv;
                        mrun_q[TMI'(word_i.slot - 4'd1)] <= 1'b1;
                      end
                      CMD_START_TMR: begin
                        remain_q[TMI'(word_i.slot - 4'd1)] <=
                          reload_q[TMI'(word_i.slot - 4'd1)];
                        mrun_q[TMI'(word_i.slot - 4'd1)] <= 1'b1;
                      end
                      default: mrun_q[TMI'(word_i.slot - 4'd1)] <= 1'b0;
                    endcase
                  end
                end
                default: ;
              endcase
            end
          end
        end
        S_MOD: begin
          if (md_done) begin
            state_q <= S_IDLE; valid_o <= 1'b1;
            unique case (w_q.cmd)
              CMD_REG_TASK: if (md_zero && w_q.tv >= 32'(tick)
                                && 32'(ntask_q) < NUM_TASKS) begin
                elapsed_q[TKI'(ntask_q)] <= '0;
                trun_q[TKI'(ntask_q)] <= 1'b1;
                ntask_q <= ntask_q + TKW'(1);
                ok_o <= 1'b1; new_id_o <= 4'(ntask_q + TKW'(1));
              end
              CMD_SET_PERIOD: if (tvalid && md_zero && w_q.tv >= 32'(tick))
                ok_o <= 1'b1;
              CMD_REG_TIMER: if (md_zero && 32'(ntmr_q) < 32'(cap)) begin
                remain_q[TMI'(ntmr_q)] <= w_q.tv;
                mrun_q[TMI'(ntmr_q)] <= 1'b0;
                ntmr_q <= ntmr_q + TMW'(1);
                ok_o <= 1'b1; new_id_o <= 4'(ntmr_q + TMW'(1));
              end
              default: ;
            endcase
          end
        end
        S_TMR: begin
          if (cap == 4'd0 || 32'(idx_q) >= 32'(ntmr_q)) begin
            idx_q <= '0; state_q <= S_TSK;
          end else begin
            if (mrun_q[mi] && remain_q[mi] != 32'd0) begin
              if (remain_q[mi] <= 32'(tick)) begin
                remain_q[mi] <= '0;
                if (32'(idx_q) < 8) xm_q[3'(idx_q)] <= 1'b1;
              end else remain_q[mi] <= remain_q[mi] - 32'(tick);
            end
            idx_q <= idx_q + IW'(1);
          end
        end
        S_TSK: begin
          if (32'(idx_q) >= 32'(ntask_q)) begin
            state_q <= S_IDLE; valid_o <= 1'b1; ok_o <= 1'b1;
            task_fire_mask_o <= tm_q; timer_fire_mask_o <= xm_q;
          end else begin
            if (trun_q[ti] && enew >= period_q[ti]) begin
              elapsed_q[ti] <= '0;
              if (32'(idx_q) < 8) tm_q[3'(idx_q)] <= 1'b1;
            end else elapsed_q[ti] <= enew;
            idx_q <= idx_q + IW'(1);
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ntask_q) <= NUM_TASKS) else $error("task count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ntmr_q) <= NUM_TIMERS) else $error("timer count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q != S_IDLE || avail_i)) else $error("spurious result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MOD && md_done) |=> valid_o) else $error("lost result");
endmodule
`default_nettype wire

FILE: rtl/periodic_task_and_timer_scheduler_unit.sv
// Top level: config registers, command queue front end, executing back end.
// Depends on ptts_pkg, ptts_front, ptts_back.
//   channel | signals                               | dir
//   command | start_i busy_o cmd_i slot_id_i time_value_i | in
//   result  | done_o ok_o new_id_o read_value_o masks | out
//   config  | cfg_we_i cfg_idx_i cfg_data_i          | in
// Simple commands finish straight from the idle state; register and set-period
// commands pass through the two-bit-per-cycle remainder unit; a tick walks the
// counted timers (none at zero capacity), then the registered tasks.
// Reset clears all counts and flags; no clearing pass. done_o cannot stall.
`default_nettype none
module periodic_task_and_timer_scheduler_unit
  import ptts_pkg::*;
#(
  parameter int NUM_TASKS  = 8,
  parameter int NUM_TIMERS = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [3:0]  cmd_i,
  input  wire logic [3:0]  slot_id_i,
  input  wire logic [31:0] time_value_i,
  output logic             done_o,
  output logic             ok_o,
  output logic [3:0]       new_id_o,
  output logic [31:0]      read_value_o,
  output logic [7:0]       task_fire_mask_o,
  output logic [7:0]       timer_fire_mask_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  logic [15:0] tick_len_q;
  logic [3:0]  tmr_cap_q;
  cmd_word_t   in_w, q_w;
  logic        full, empty, pop, idle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_len_q <= 16'd1; tmr_cap_q <= 4'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TICK_LENGTH: tick_len_q <= cfg_data_i;
        CFG_TIMER_CAP:   tmr_cap_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign in_w   = '{cmd: cmd_i, slot: slot_id_i, tv: time_value_i};
  assign busy_o = full;

  ptts_front u_front (
    .clk_i, .rst_ni, .push_i(start_i), .word_i(in_w), .pop_i(pop),
    .full_o(full), .empty_o(empty), .word_o(q_w)
  );

  ptts_back #(.NUM_TASKS(NUM_TASKS), .NUM_TIMERS(NUM_TIMERS)) u_back (
    .clk_i, .rst_ni, .avail_i(!empty), .word_i(q_w), .pop_o(pop),
    .tick_len_i(tick_len_q), .tmr_cap_i(tmr_cap_q), .valid_o(done_o),
    .ok_o, .new_id_o, .read_value_o, .task_fire_mask_o, .timer_fire_mask_o,
    .idle_o(idle)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (empty && idle && !start_i) |=> !done_o) else $error("result while idle");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !$past(done_o) || $past(!empty)) else $error("duplicate result");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !empty) else $error("pop from empty queue");
endmodule
`default_nettype wire
